/* hw/rtl/mcd_pkg.sv */
package mcd_pkg;

  localparam int TpmW    = 16;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SegW    = 8;
  localparam int DigitW  = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;

  localparam logic [CfgIdxW-1:0] REG_TICKS_PER_MINUTE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OPEN_HOUR        = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CLOSE_HOUR       = 2'd2;

  localparam logic [TpmW-1:0]    TPM_RESET        = 16'd40;
  localparam logic [HourW-1:0]   OPEN_HOUR_RESET  = 5'd6;
  localparam logic [HourW-1:0]   CLOSE_HOUR_RESET = 5'd22;
  localparam logic [HourW-1:0]   HOUR_RESET       = 5'd5;
  localparam logic [MinuteW-1:0] MINUTE_RESET     = 6'd57;
  localparam logic [HourW-1:0]   HOUR_LAST        = 5'd23;
  localparam logic [MinuteW-1:0] MINUTE_LAST      = 6'd59;

  localparam logic [SegW-1:0] DP_MASK = 8'h01;

  typedef logic [SegW-1:0] seg_font_t [10];
  localparam seg_font_t SEG_FONT = '{
    8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1F, 8'h01, 8'h09
  };

  typedef enum logic [DigitW-1:0] {
    DIG_HOUR_TENS  = 2'd0,
    DIG_HOUR_UNITS = 2'd1,
    DIG_MIN_TENS   = 2'd2,
    DIG_MIN_UNITS  = 2'd3
  } digit_t;

  typedef struct packed {
    logic [MinuteW-1:0] minute_now;
    logic [HourW-1:0]   hour_now;
    logic               is_open;
    logic               status_event;
    logic [DigitW-1:0]  digit_select;
    logic [SegW-1:0]    segments;
  } result_t;

  function automatic logic [SegW-1:0] font_of(input logic [3:0] d);
    logic [SegW-1:0] f;
    f = 8'hFF;
    if (d < 4'd10) begin
      f = SEG_FONT[d];
    end
    return f;
  endfunction

  // tens digit of a value below 64
  function automatic logic [3:0] tens_of(input logic [MinuteW-1:0] v);
    logic [3:0] t;
    if (v >= 6'd60) t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else t = 4'd0;
    return t;
  endfunction

  function automatic logic [3:0] units_of(input logic [MinuteW-1:0] v);
    logic [9:0] prod;
    prod = 10'(tens_of(v)) * 10'd10;
    return 4'(10'(v) - prod);
  endfunction

endpackage

/* hw/rtl/mcd_core.sv */
module mcd_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mcd_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [mcd_pkg::CfgW-1:0]        cfg_data,
  input  logic                            accept,
  input  logic                            tick,
  output mcd_pkg::result_t                result
);
  import mcd_pkg::*;

  logic [TpmW-1:0]    ticks_per_minute;
  logic [HourW-1:0]   open_hour;
  logic [HourW-1:0]   close_hour;

  digit_t             digit_index, digit_index_next;
  logic [TpmW-1:0]    tick_count, tick_count_next;
  logic [HourW-1:0]   hour_reg, hour_reg_next;
  logic [MinuteW-1:0] minute_reg, minute_reg_next;
  logic               open_flag, open_flag_next;
  logic               closed_flag, closed_flag_next;

  logic [TpmW:0]      count_inc;
  logic               roll;
  logic               win_open;
  logic               event_flag;
  logic [SegW-1:0]    seg;
  logic [MinuteW-1:0] hour_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_minute <= TPM_RESET;
      open_hour        <= OPEN_HOUR_RESET;
      close_hour       <= CLOSE_HOUR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICKS_PER_MINUTE: ticks_per_minute <= cfg_data;
        REG_OPEN_HOUR:        open_hour        <= cfg_data[HourW-1:0];
        REG_CLOSE_HOUR:       close_hour       <= cfg_data[HourW-1:0];
        default: ;
      endcase
    end
  end

  assign hour_wide = MinuteW'(hour_reg);

  // digit shown from the time before this item
  always_comb begin
    unique case (digit_index)
      DIG_HOUR_TENS:  seg = font_of(tens_of(hour_wide));
      DIG_HOUR_UNITS: seg = font_of(units_of(hour_wide)) ^ DP_MASK;
      DIG_MIN_TENS:   seg = font_of(tens_of(minute_reg));
      DIG_MIN_UNITS:  seg = font_of(units_of(minute_reg));
      default:        seg = font_of(units_of(minute_reg));
    endcase
  end

  assign count_inc = {1'b0, tick_count} + 1'b1;
  assign roll      = tick && (count_inc >= {1'b0, ticks_per_minute});

  always_comb begin
    digit_index_next = digit_index;
    tick_count_next  = tick_count;
    minute_reg_next  = minute_reg;
    hour_reg_next    = hour_reg;
    if (tick) begin
      digit_index_next = digit_t'(digit_index + 2'd1);
      tick_count_next  = count_inc[TpmW-1:0];
    end
    if (roll) begin
      tick_count_next = '0;
      if (minute_reg >= MINUTE_LAST) begin
        minute_reg_next = '0;
        hour_reg_next   = (hour_reg >= HOUR_LAST) ? '0 : hour_reg + 1'b1;
      end else begin
        minute_reg_next = minute_reg + 1'b1;
      end
    end
  end

  // daily window, wraps midnight when open hour is after close hour, closed when equal
  always_comb begin
    if (open_hour < close_hour) begin
      win_open = (hour_reg_next >= open_hour) && (hour_reg_next < close_hour);
    end else if (open_hour > close_hour) begin
      win_open = (hour_reg_next >= open_hour) || (hour_reg_next < close_hour);
    end else begin
      win_open = 1'b0;
    end
  end

  always_comb begin
    open_flag_next   = open_flag;
    closed_flag_next = closed_flag;
    event_flag       = 1'b0;
    if (roll) begin
      if (!win_open) begin
        if (!closed_flag) begin
          closed_flag_next = 1'b1;
          open_flag_next   = 1'b0;
          event_flag       = 1'b1;
        end
      end else if (!open_flag) begin
        open_flag_next   = 1'b1;
        closed_flag_next = 1'b0;
        event_flag       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_index <= DIG_HOUR_TENS;
      tick_count  <= '0;
      hour_reg    <= HOUR_RESET;
      minute_reg  <= MINUTE_RESET;
      open_flag   <= 1'b0;
      closed_flag <= 1'b0;
    end else if (accept) begin
      digit_index <= digit_index_next;
      tick_count  <= tick_count_next;
      hour_reg    <= hour_reg_next;
      minute_reg  <= minute_reg_next;
      open_flag   <= open_flag_next;
      closed_flag <= closed_flag_next;
    end
  end

  always_comb begin
    result.segments     = seg;
    result.digit_select = digit_index;
    result.status_event = event_flag;
    result.is_open      = open_flag_next;
    result.hour_now     = hour_reg_next;
    result.minute_now   = minute_reg_next;
  end

endmodule

/* hw/rtl/mcd_out.sv */
module mcd_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mcd_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mcd_pkg::result_t out_data
);
  import mcd_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    accept;
  logic    drain;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign drain    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (accept) begin
      skid_data <= in_data;
    end
  end

endmodule

/* hw/rtl/multiplexed_clock_display.sv */
// Four-digit multiplexed seven-segment clock. Each input item is one timer
// tick (tdata bit 0; 0 shows the current digit without advancing). Every item
// yields one result: the active-low segments of the digit at the current
// position (hour tens, hour units with decimal point, minute tens, minute
// units) taken from the time before the tick, then the time after the tick and
// the open/closed window state, with status_event set when a minute roll
// changed that state or first set it after reset. Items pass through the time
// update logic into the output register; one is accepted every cycle while the
// skid entry is empty, and while a result waits the two-entry output stage
// takes one more item and then holds the input. Configuration writes are
// applied in the cycle after cfg_we and should be made while idle.
module multiplexed_clock_display (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mcd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [mcd_pkg::CfgW-1:0]    cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // tick[0], zero pad
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // segments[7:0], status_event[8], is_open[9], hour_now[14:10],
  // minute_now[20:15], zero pad
  output logic [23:0]                 m_tdata,
  output logic [1:0]                  m_tuser   // digit_select[1:0]
);
  import mcd_pkg::*;

  result_t core_result;
  result_t out_result;
  logic    accept;

  assign accept = s_tvalid && s_tready;

  mcd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .tick      (s_tdata[0]),
    .result    (core_result)
  );

  mcd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (core_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = {3'b000, out_result.minute_now, out_result.hour_now,
                    out_result.is_open, out_result.status_event,
                    out_result.segments};
  assign m_tuser = out_result.digit_select;

endmodule
